// ===== hw/rtl/mcwt_pkg.sv =====
package mcwt_pkg;

    localparam int ID_W = 16;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_FEED      = 3'd2,
        OP_CHECK_ONE = 3'd3,
        OP_CHECK_ALL = 3'd4,
        OP_NONE      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // request token that walks the row of slot cells
    typedef struct packed {
        logic            valid;
        t_op             op;
        logic [ID_W-1:0] id;
        logic            done;   // a cell already took the request
        logic            bad;    // zero id on an id-based request
    } t_tok;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_rpt;

endpackage

// ===== hw/rtl/multi_client_watchdog_table.sv =====
// a status result is registered on m_axis once the request token has passed r_tok_in and every
// slot cell; the whole row stalls while a report or status waits on m_axis_tready
// the request token walks the row of slot cells one cell per cycle while m_axis is not stalled,
// and the next item is taken only once the status of the previous one is registered
// reset: synchronous active-low i_rst_n empties every slot, clears all hungry flags and count
module multi_client_watchdog_table #(
    parameter int MAX_CLIENTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // action[2:0], client_id[18:3], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[1:0], starved_id[17:2], zero pad
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

    mcwt_pkg::t_tok            r_tok_in;
    mcwt_pkg::t_tok            w_tok [MAX_CLIENTS+1];
    mcwt_pkg::t_rpt            w_rpt [MAX_CLIENTS];
    mcwt_pkg::t_tok            w_exit;
    mcwt_pkg::t_op             w_op;
    mcwt_pkg::t_status         w_status;
    logic [2:0]                w_action;
    logic [mcwt_pkg::ID_W-1:0] w_cid;
    logic                      w_accept;
    logic                      w_adv;
    logic                      w_rpt_any;
    logic [mcwt_pkg::ID_W-1:0] w_rpt_id;
    logic [MAX_CLIENTS-1:0]    w_rpt_vld;
    logic [MAX_CLIENTS:0]      w_tok_vld;
    logic                      r_busy;
    logic [CNT_W-1:0]          r_live;
    logic                      r_out_valid;
    logic                      r_kind;
    mcwt_pkg::t_status         r_status;
    logic [mcwt_pkg::ID_W-1:0] r_id;
    logic                      r_last;

    assign w_action      = s_axis_tdata[2:0];
    assign w_cid         = s_axis_tdata[18:3];
    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_adv         = !r_out_valid || m_axis_tready;

    always_comb begin
        unique case (w_action)
            mcwt_pkg::OP_APPEND:    w_op = mcwt_pkg::OP_APPEND;
            mcwt_pkg::OP_REMOVE:    w_op = mcwt_pkg::OP_REMOVE;
            mcwt_pkg::OP_FEED:      w_op = mcwt_pkg::OP_FEED;
            mcwt_pkg::OP_CHECK_ONE: w_op = mcwt_pkg::OP_CHECK_ONE;
            mcwt_pkg::OP_CHECK_ALL: w_op = mcwt_pkg::OP_CHECK_ALL;
            default:                w_op = mcwt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_in <= '0;
        end else if (w_accept) begin
            r_tok_in.valid <= 1'b1;
            r_tok_in.op    <= w_op;
            r_tok_in.id    <= w_cid;
            r_tok_in.done  <= 1'b0;
            r_tok_in.bad   <= (w_cid == '0) && (w_action <= mcwt_pkg::OP_CHECK_ONE);
        end else if (w_adv) begin
            r_tok_in.valid <= 1'b0;
        end
    end

    assign w_tok[0] = r_tok_in;

    for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
        mcwt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_rpt   (w_rpt[g])
        );
    end

    assign w_exit = w_tok[MAX_CLIENTS];

    // only one token is in the row, so at most one cell reports per cycle
    always_comb begin
        w_rpt_any = 1'b0;
        w_rpt_id  = '0;
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            w_rpt_vld[i] = w_rpt[i].valid;
            w_rpt_any    = w_rpt_any | w_rpt[i].valid;
            w_rpt_id     = w_rpt_id | (w_rpt[i].id & {mcwt_pkg::ID_W{w_rpt[i].valid}});
        end
        for (int i = 0; i <= MAX_CLIENTS; i++) begin
            w_tok_vld[i] = w_tok[i].valid;
        end
    end

    always_comb begin
        if (w_exit.bad) begin
            w_status = mcwt_pkg::ST_INVALID;
        end else if (w_exit.op == mcwt_pkg::OP_APPEND && !w_exit.done) begin
            w_status = mcwt_pkg::ST_FULL;
        end else if ((w_exit.op == mcwt_pkg::OP_REMOVE || w_exit.op == mcwt_pkg::OP_FEED ||
                      w_exit.op == mcwt_pkg::OP_CHECK_ONE) && !w_exit.done) begin
            w_status = mcwt_pkg::ST_NOT_FOUND;
        end else begin
            w_status = mcwt_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_live      <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_exit.valid) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_rpt_any || w_exit.valid;
                if (w_exit.valid && !w_exit.bad && w_exit.done) begin
                    if (w_exit.op == mcwt_pkg::OP_APPEND) begin
                        r_live <= r_live + CNT_W'(1);
                    end else if (w_exit.op == mcwt_pkg::OP_REMOVE && r_live != '0) begin
                        r_live <= r_live - CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_rpt_any) begin
                r_kind   <= mcwt_pkg::KIND_REPORT;
                r_status <= mcwt_pkg::ST_OK;
                r_id     <= w_rpt_id;
                r_last   <= 1'b0;
            end else begin
                r_kind   <= mcwt_pkg::KIND_STATUS;
                r_status <= w_status;
                r_id     <= '0;
                r_last   <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_id, r_status};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

    a_one_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_rpt_vld))
        else $error("more than one cell reported in a cycle");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one request token in the cell row");

    a_busy_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (w_tok_vld != '0))
        else $error("busy flag disagrees with token presence");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_CLIENTS))
        else $error("live count above table size");

endmodule

// ===== hw/rtl/mcwt_cell.sv =====
module mcwt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  mcwt_pkg::t_tok i_tok,
    output mcwt_pkg::t_tok o_tok,
    output mcwt_pkg::t_rpt o_rpt
);

    logic [mcwt_pkg::ID_W-1:0] r_owner, n_owner;
    logic                      r_hungry, n_hungry;
    mcwt_pkg::t_tok            r_tok, n_tok;
    logic                      w_match;

    assign w_match = (r_owner == i_tok.id) && !i_tok.done;

    always_comb begin
        n_owner   = r_owner;
        n_hungry  = r_hungry;
        n_tok     = i_tok;
        o_rpt     = '0;
        if (i_tok.valid && !i_tok.bad) begin
            unique case (i_tok.op)
                mcwt_pkg::OP_APPEND: begin
                    if (!i_tok.done && (r_owner == '0)) begin
                        n_owner    = i_tok.id;
                        n_hungry   = 1'b0;
                        n_tok.done = 1'b1;
                    end
                end
                mcwt_pkg::OP_REMOVE: begin
                    if (w_match) begin
                        n_owner    = '0;
                        n_tok.done = 1'b1;
                    end
                end
                mcwt_pkg::OP_FEED: begin
                    if (w_match) begin
                        n_hungry   = 1'b0;
                        n_tok.done = 1'b1;
                    end
                end
                mcwt_pkg::OP_CHECK_ONE: begin
                    if (w_match) begin
                        o_rpt.valid = r_hungry;
                        o_rpt.id    = r_hungry ? r_owner : '0;
                        n_hungry    = 1'b1;
                        n_tok.done  = 1'b1;
                    end
                end
                mcwt_pkg::OP_CHECK_ALL: begin
                    if ((r_owner != '0) && r_hungry) begin
                        o_rpt.valid = 1'b1;
                        o_rpt.id    = r_owner;
                    end
                    n_hungry = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner  <= '0;
            r_hungry <= 1'b0;
            r_tok    <= '0;
        end else if (i_adv) begin
            r_owner  <= n_owner;
            r_hungry <= n_hungry;
            r_tok    <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_CLIENTS = 8;
    localparam int STALL_LIMIT = 2000;     // cycles with no transfer on either side
    localparam int LONG_HOLD = 300;        // receiver hold-off in the pressure test
    localparam logic [2:0] OP_CODE_MAX = 3'd7;

    typedef struct packed {
        logic                      kind;
        mcwt_pkg::t_status         status;
        logic [mcwt_pkg::ID_W-1:0] starved_id;
        logic                      last;
    } t_wd_result;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // action[2:0], client_id[18:3], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // status[1:0], starved_id[17:2], zero pad
    logic        m_axis_tuser;         // kind
    logic        m_axis_tlast;

    // predicted table contents
    logic [mcwt_pkg::ID_W-1:0] table_id [MAX_CLIENTS];
    logic                      table_hungry [MAX_CLIENTS];
    int unsigned               table_used;

    t_wd_result pending_results[$];
    t_wd_result want;

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned starved_reports;
    int unsigned full_hits;
    int unsigned idle_cycles;
    int unsigned rx_wait;
    int unsigned rx_hold_req;
    bit          rx_calm;
    bit          tx_calm;

    multi_client_watchdog_table #(
        .MAX_CLIENTS(MAX_CLIENTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic int find_slot(logic [mcwt_pkg::ID_W-1:0] id);
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            if (table_id[i] == id) begin
                return i;
            end
        end
        return MAX_CLIENTS;
    endfunction

    function automatic void push_result(logic kind, mcwt_pkg::t_status st,
                                        logic [mcwt_pkg::ID_W-1:0] id, logic last);
        t_wd_result r;
        r.kind = kind;
        r.status = st;
        r.starved_id = id;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    // updates the predicted table for one request and queues the results it causes
    function automatic void apply_request(logic [2:0] op, logic [mcwt_pkg::ID_W-1:0] id);
        int                slot;
        mcwt_pkg::t_status st;
        st = mcwt_pkg::ST_OK;
        if (op == mcwt_pkg::OP_CHECK_ALL) begin
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                if (table_id[i] != '0 && table_hungry[i]) begin
                    push_result(mcwt_pkg::KIND_REPORT, mcwt_pkg::ST_OK, table_id[i], 1'b0);
                    starved_reports++;
                end
                table_hungry[i] = 1'b1;
            end
        end else if (op <= mcwt_pkg::OP_CHECK_ONE) begin
            if (id == '0) begin
                st = mcwt_pkg::ST_INVALID;
            end else if (op == mcwt_pkg::OP_APPEND) begin
                slot = find_slot('0);
                if (slot >= MAX_CLIENTS) begin
                    st = mcwt_pkg::ST_FULL;
                    full_hits++;
                end else begin
                    table_id[slot] = id;
                    table_hungry[slot] = 1'b0;
                    table_used++;
                end
            end else begin
                slot = find_slot(id);
                if (slot >= MAX_CLIENTS) begin
                    st = mcwt_pkg::ST_NOT_FOUND;
                end else if (op == mcwt_pkg::OP_REMOVE) begin
                    table_id[slot] = '0;
                    if (table_used > 0) begin
                        table_used--;
                    end
                end else if (op == mcwt_pkg::OP_FEED) begin
                    table_hungry[slot] = 1'b0;
                end else begin
                    if (table_hungry[slot]) begin
                        push_result(mcwt_pkg::KIND_REPORT, mcwt_pkg::ST_OK, id, 1'b0);
                        starved_reports++;
                    end
                    table_hungry[slot] = 1'b1;
                end
            end
        end
        push_result(mcwt_pkg::KIND_STATUS, st, '0, 1'b1);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
        if (fail_count < 20) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp_val);
        end
        fail_count++;
    endtask

    task automatic send_item(logic [2:0] op, logic [mcwt_pkg::ID_W-1:0] id, bit may_idle);
        int unsigned gap;
        if ($urandom_range(0, 49) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = (may_idle && !tx_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, id, op};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        apply_request(op, id);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // zero id is rejected by every id-based op
        send_item(mcwt_pkg::OP_APPEND, 16'h0000, 1'b1);
        send_item(mcwt_pkg::OP_REMOVE, 16'h0000, 1'b1);
        send_item(mcwt_pkg::OP_FEED, 16'h0000, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ONE, 16'h0000, 1'b1);
        // empty table, nothing to find
        send_item(mcwt_pkg::OP_REMOVE, 16'h1234, 1'b1);
        send_item(mcwt_pkg::OP_FEED, 16'h1234, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ONE, 16'h1234, 1'b1);
        // fill every slot, with one duplicate
        send_item(mcwt_pkg::OP_APPEND, 16'hFFFF, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h0001, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'hA5A5, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h5A5A, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h0001, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h8000, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h7FFF, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h0002, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h0003, 1'b1);
        // first check of a fed client is quiet, the second reports it
        send_item(mcwt_pkg::OP_CHECK_ONE, 16'h0001, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ONE, 16'h0001, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ALL, 16'h0000, 1'b1);
        send_item(mcwt_pkg::OP_FEED, 16'hA5A5, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ALL, 16'hFFFF, 1'b1);
        // remove takes the lower copy, refill leaves the new client fed
        send_item(mcwt_pkg::OP_REMOVE, 16'h0001, 1'b1);
        send_item(mcwt_pkg::OP_APPEND, 16'h0004, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ALL, 16'h0000, 1'b1);
        send_item(mcwt_pkg::OP_CHECK_ALL, 16'h0000, 1'b1);
        send_item(mcwt_pkg::OP_NONE, 16'hFFFF, 1'b1);
        send_item(OP_CODE_MAX, 16'h0001, 1'b1);
    endtask

    task automatic test_random(int count);
        logic [mcwt_pkg::ID_W-1:0] pool [12];
        logic [2:0]                op;
        logic [mcwt_pkg::ID_W-1:0] id;
        int unsigned               r;
        foreach (pool[i]) begin
            pool[i] = 16'($urandom_range(1, 16'hFFFF));
        end
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 28) begin
                op = mcwt_pkg::OP_APPEND;
            end else if (r < 42) begin
                op = mcwt_pkg::OP_REMOVE;
            end else if (r < 62) begin
                op = mcwt_pkg::OP_FEED;
            end else if (r < 77) begin
                op = mcwt_pkg::OP_CHECK_ONE;
            end else if (r < 93) begin
                op = mcwt_pkg::OP_CHECK_ALL;
            end else begin
                op = 3'($urandom_range(mcwt_pkg::OP_NONE, OP_CODE_MAX));
            end
            r = $urandom_range(0, 19);
            if (r == 0) begin
                id = '0;
            end else if (r == 1) begin
                id = 16'($urandom);
            end else begin
                id = pool[$urandom_range(0, 11)];
            end
            send_item(op, id, 1'b1);
        end
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_backpressure();
        @(posedge i_clk);
        rx_hold_req = LONG_HOLD;
        send_item(mcwt_pkg::OP_APPEND, 16'h0BAD, 1'b0);
        send_item(mcwt_pkg::OP_APPEND, 16'hF00D, 1'b0);
        repeat (14) begin
            send_item(3'($urandom_range(mcwt_pkg::OP_APPEND, mcwt_pkg::OP_CHECK_ALL)),
                      16'($urandom), 1'b0);
        end
        send_item(mcwt_pkg::OP_CHECK_ALL, 16'h0000, 1'b0);
        send_item(mcwt_pkg::OP_CHECK_ALL, 16'h0000, 1'b0);
    endtask

    // sender waits for the block to go quiet between short bursts
    task automatic test_drain_pause();
        repeat (3) begin
            wait_for_results();
            send_item(mcwt_pkg::OP_CHECK_ALL, 16'h0000, 1'b1);
            send_item(mcwt_pkg::OP_FEED, 16'($urandom), 1'b1);
        end
    endtask

    // receiver: random hold-offs, calm stretches, and the long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_wait = rx_hold_req;
            rx_hold_req = 0;
        end
        if ($urandom_range(0, 99) == 0) begin
            rx_calm = !rx_calm;
        end
        if (rx_wait != 0) begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) begin
                rx_wait = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", 32'(m_axis_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
                end
                if (m_axis_tdata[1:0] !== want.status) begin
                    report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
                end
                if (m_axis_tdata[17:2] !== want.starved_id) begin
                    report_mismatch("starved id", 32'(m_axis_tdata[17:2]),
                                    32'(want.starved_id));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     idle_cycles, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        foreach (table_id[i]) begin
            table_id[i] = '0;
            table_hungry[i] = 1'b0;
        end
        table_used = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(110);
        test_backpressure();
        test_drain_pause();

        wait_for_results();
        repeat (2 * MAX_CLIENTS + 8) @(posedge i_clk);

        $display("%0d requests, %0d results checked, %0d starved reports",
                 items_sent, results_seen, starved_reports);
        $display("table full %0d times, %0d clients left in table, %0d mismatches",
                 full_hits, table_used, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mcwt_pkg.sv
hw/rtl/mcwt_cell.sv
hw/rtl/multi_client_watchdog_table.sv
sim/testbench.sv
